/* src/fltq_pkg.sv */
// Shared types and codes for the four-level trap queue.
// Holds the transfer payload structs, operation codes and status codes.
// No dependencies.
`default_nettype none

package fltq_pkg;

  localparam int unsigned NumModes = 4;

  localparam logic [1:0] OP_DECLARE = 2'd0;
  localparam logic [1:0] OP_SET_EN  = 2'd1;
  localparam logic [1:0] OP_DELIVER = 2'd2;
  localparam logic [1:0] OP_FLUSH   = 2'd3;

  localparam logic [2:0] ST_NORMAL   = 3'd0;
  localparam logic [2:0] ST_BADPARAM = 3'd1;
  localparam logic [2:0] ST_NOPRIV   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_WASSET   = 3'd4;
  localparam logic [2:0] ST_WASCLR   = 3'd5;
  localparam logic [2:0] ST_NONE     = 3'd6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  target_mode;
    logic [1:0]  caller_mode;
    logic        may_change_to_kernel;
    logic        may_change_to_exec;
    logic [63:0] routine_address;
    logic [63:0] routine_param;
    logic        enable_flag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_routine_address;
    logic [63:0] out_routine_param;
    logic [1:0]  delivered_mode;
  } out_item_t;

endpackage

`default_nettype wire

/* src/four_level_trap_queue.sv */
// Four-level trap queue: top level with per-mode queue control and entry memory.
// Depends on fltq_pkg for payload structs and operation and status codes.
//
// One item is handled at a time. An accepted item is registered, then worked
// on in S_EXEC from the per-mode head and count registers; declare writes
// the entry memory there. Declare, set enable, flush and a deliver that
// finds nothing give their result from S_EXEC; a deliver that pops an entry
// gives it from S_READ, after a registered read of the entry memory
// (4*QUEUE_DEPTH entries of address and parameter). The next item is taken
// as soon as the result sits in the output register, even while it is stalled.
`default_nettype none

module four_level_trap_queue
  import fltq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  localparam int unsigned PtrW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW     = CntW + 1;
  localparam int unsigned MemDepth = NumModes * QUEUE_DEPTH;
  localparam int unsigned AddrW    = $clog2(MemDepth);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]      state_q, state_d;
  in_item_t        item_q;
  out_item_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [PtrW-1:0] head_q [NumModes];
  logic [PtrW-1:0] head_d [NumModes];
  logic [CntW-1:0] cnt_q  [NumModes];
  logic [CntW-1:0] cnt_d  [NumModes];
  logic [NumModes-1:0] en_q, en_d;
  logic [1:0]      dmode_q, dmode_d;

  logic [127:0]    mem [MemDepth];
  logic [127:0]    rdata_q;
  logic            mem_we, mem_re;
  logic [AddrW-1:0] mem_addr;

  logic            in_xfer, go;
  logic            hit;
  logic [1:0]      hit_mode, sel_mode;
  logic [PtrW-1:0] sel_head;
  logic [CntW-1:0] sel_cnt;
  logic [SumW-1:0] tail_sum;
  logic [PtrW-1:0] tail_slot, slot;
  logic            bad, nopriv, full;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign go          = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    hit      = 1'b0;
    hit_mode = 2'd0;
    for (int m = NumModes - 1; m >= 0; m--) begin
      if (2'(m) >= item_q.caller_mode && en_q[m] && cnt_q[m] != '0) begin
        hit      = 1'b1;
        hit_mode = 2'(m);
      end
    end
  end

  assign sel_mode  = (item_q.opcode == OP_DECLARE) ? item_q.target_mode[1:0] : hit_mode;
  assign sel_head  = head_q[sel_mode];
  assign sel_cnt   = cnt_q[sel_mode];
  assign tail_sum  = SumW'(sel_head) + SumW'(sel_cnt);
  assign tail_slot = (tail_sum >= SumW'(QUEUE_DEPTH)) ?
                     PtrW'(tail_sum - SumW'(QUEUE_DEPTH)) : PtrW'(tail_sum);
  assign slot      = (item_q.opcode == OP_DECLARE) ? tail_slot : sel_head;
  assign mem_addr  = AddrW'(sel_mode) * AddrW'(QUEUE_DEPTH) + AddrW'(slot);

  assign bad    = item_q.target_mode[2] || (item_q.routine_address == '0);
  assign nopriv = (item_q.target_mode[1:0] < item_q.caller_mode) &&
                  !item_q.may_change_to_kernel &&
                  ((item_q.target_mode[1:0] == 2'd0) || !item_q.may_change_to_exec);
  assign full   = (sel_cnt == CntW'(QUEUE_DEPTH));

  always_comb begin
    state_d     = state_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    en_d        = en_q;
    dmode_d     = dmode_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          out_d       = '0;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          case (item_q.opcode)
            OP_DECLARE: begin
              if (bad) begin
                out_d.status = ST_BADPARAM;
              end else if (nopriv) begin
                out_d.status = ST_NOPRIV;
              end else if (full) begin
                out_d.status = ST_FULL;
              end else begin
                out_d.status    = ST_NORMAL;
                mem_we          = 1'b1;
                cnt_d[sel_mode] = sel_cnt + CntW'(1);
              end
            end
            OP_SET_EN: begin
              out_d.status = en_q[item_q.caller_mode] ? ST_WASSET : ST_WASCLR;
              en_d[item_q.caller_mode] = item_q.enable_flag;
            end
            OP_DELIVER: begin
              if (hit) begin
                out_valid_d      = 1'b0;
                mem_re           = 1'b1;
                dmode_d          = hit_mode;
                state_d          = S_READ;
                head_d[sel_mode] = (sel_head == PtrW'(QUEUE_DEPTH - 1)) ?
                                   '0 : sel_head + PtrW'(1);
                cnt_d[sel_mode]  = sel_cnt - CntW'(1);
              end else begin
                out_d.status = ST_NONE;
              end
            end
            default: begin
              out_d.status = ST_NORMAL;
              for (int m = 0; m < NumModes; m++) begin
                if (!item_q.target_mode[2] && 2'(m) >= item_q.target_mode[1:0]) begin
                  head_d[m] = '0;
                  cnt_d[m]  = '0;
                end
              end
            end
          endcase
        end
      end
      S_READ: begin
        if (go) begin
          out_valid_d = 1'b1;
          out_d       = {ST_NORMAL, rdata_q[127:64], rdata_q[63:0], dmode_q};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      en_q        <= '1;
      for (int m = 0; m < NumModes; m++) begin
        head_q[m] <= '0;
        cnt_q[m]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      en_q        <= en_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_data_i;
    end
    out_q   <= out_d;
    dmode_q <= dmode_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= {item_q.routine_address, item_q.routine_param};
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= CntW'(QUEUE_DEPTH) && cnt_q[1] <= CntW'(QUEUE_DEPTH) &&
    cnt_q[2] <= CntW'(QUEUE_DEPTH) && cnt_q[3] <= CntW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_mem_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("entry memory read and written together");

  a_read_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> !out_valid_q)
    else $error("output register occupied during entry read");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_READ))
    else $error("result appeared without work");

endmodule

`default_nettype wire
